>>> hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, codes and helpers for the wav stream decoder and downmixer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int MaxChannels = 8;
  localparam int ChanW = $clog2(MaxChannels + 1);

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_FMT_INC   = 3'd3;
  localparam logic [2:0] ST_DEPTH     = 3'd4;
  localparam logic [2:0] ST_UNSUPP    = 3'd5;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHUNK, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_SINK
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE, C_DIV, C_OUT_SAMPLE, C_OUT_FINAL
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic parse;      // consume the held byte
    logic div_start;  // start the downmix divide
    logic clear;      // back to reset after final report
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done; // parse produced a full frame
    logic div_busy;
  } dp_stat_t;

  function automatic logic signed [31:0] pcm_q23(input logic [31:0] w);
    pcm_q23 = $signed(w) >>> 8;
  endfunction

  function automatic logic signed [31:0] float_q23(input logic [31:0] w);
    logic [7:0]  e;
    logic [26:0] m;
    logic [26:0] mag;
    e = w[30:23];
    m = {3'd0, 1'b1, w[22:0]};
    if (e == 8'hFF || e == 8'd0) mag = '0;
    else if (e >= 8'd130) mag = 27'h4000000;
    else if (e >= 8'd127) mag = m << (e - 8'd127);
    else if ((8'd127 - e) >= 8'd24) mag = '0;
    else mag = m >> (8'd127 - e);
    float_q23 = w[31] ? -$signed({5'd0, mag}) : $signed({5'd0, mag});
  endfunction

endpackage

>>> hdl/wsd_stream_if.sv
// ----------------------------------------------------------------------------
// wsd_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface wsd_stream_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/wsd_divider.sv
// ----------------------------------------------------------------------------
// wsd_divider
// Signed restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module wsd_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [31:0]           num,
  input  logic [wsd_pkg::ChanW-1:0]    den,
  output logic                         busy,
  output logic signed [31:0]           quo
);
  logic [31:0] rem_q;
  logic [31:0] q;
  logic [32:0] r;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] trial;

  always_comb begin
    trial = {r[31:0], rem_q[31]} - {{(33 - wsd_pkg::ChanW){1'b0}}, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
      rem_q <= num[31] ? 32'(-num) : num;
      neg <= num[31];
      r <= '0;
      q <= '0;
    end else if (busy) begin
      rem_q <= {rem_q[30:0], 1'b0};
      if (!trial[32]) begin
        r <= trial;
        q <= {q[30:0], 1'b1};
      end else begin
        r <= {r[31:0], rem_q[31]};
        q <= {q[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);
endmodule

>>> hdl/wsd_datapath.sv
// ----------------------------------------------------------------------------
// wsd_datapath
// Chunk walker, fmt store, sample decode and channel accumulation.
// ----------------------------------------------------------------------------
module wsd_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  wsd_pkg::dp_cmd_t     cmd,
  input  logic [7:0]           b,
  input  logic                 eof,
  output wsd_pkg::dp_stat_t    stat,
  output logic signed [23:0]   avg,
  output logic [1:0]           fin_kind,
  output logic [2:0]           fin_status,
  output logic [31:0]          rate_hz
);
  wsd_pkg::phase_t phase, phase_n;
  logic [4:0]  byte_count, byte_count_n;
  logic [31:0] tag_shift, tag_n, chunk_left, chunk_n;
  logic        pad_pending, pad_n, fmt_seen, fmt_n, data_seen, data_n;
  logic [15:0] format_code, fc_n, channel_count, cc_n, sample_bits, sb_n;
  logic [31:0] rate_store, rs_n;
  logic [2:0]  sample_bytes, sby_n;
  logic [1:0]  byte_in_sample, bis_n;
  logic [wsd_pkg::ChanW-1:0] channel_index, ci_n;
  logic signed [31:0] mix_sum, ms_n, div_num, quo;
  logic [2:0]  error_code, err_n;
  logic        frame_n;
  logic [31:0] w;
  logic signed [31:0] q;
  logic [2:0]  fe;
  logic        div_busy;
  logic        frame_done;

  wsd_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num),
    .den(channel_count[wsd_pkg::ChanW-1:0]), .busy(div_busy), .quo(quo)
  );

  always_comb begin
    if (channel_count == 16'd0 || rate_store == 32'd0) fe = wsd_pkg::ST_FMT_INC;
    else if (sample_bits[15:3] == 13'd0) fe = wsd_pkg::ST_DEPTH;
    else if (channel_count > 16'(wsd_pkg::MaxChannels)) fe = wsd_pkg::ST_UNSUPP;
    else if (format_code == 16'd1 && (sample_bits == 16'd16 || sample_bits == 16'd24
             || sample_bits == 16'd32)) fe = wsd_pkg::ST_OK;
    else if (format_code == 16'd3 && sample_bits == 16'd32) fe = wsd_pkg::ST_OK;
    else fe = wsd_pkg::ST_UNSUPP;
  end

  always_comb begin
    phase_n = phase; byte_count_n = byte_count; tag_n = tag_shift;
    chunk_n = chunk_left; pad_n = pad_pending; fmt_n = fmt_seen; data_n = data_seen;
    fc_n = format_code; cc_n = channel_count; sb_n = sample_bits; rs_n = rate_store;
    sby_n = sample_bytes; bis_n = byte_in_sample; ci_n = channel_index;
    ms_n = mix_sum; err_n = error_code; frame_n = 1'b0;
    w = (tag_shift >> 8) | {b, 24'd0};
    q = (format_code == 16'd3) ? wsd_pkg::float_q23(w) : wsd_pkg::pcm_q23(w);
    unique case (phase)
      wsd_pkg::PH_HEADER: begin
        tag_n = w;
        if (byte_count == 5'd3 && w != wsd_pkg::TAG_RIFF) begin
          if (err_n == '0) err_n = wsd_pkg::ST_NOT_WAVE;
          phase_n = wsd_pkg::PH_SINK;
        end else if (byte_count == 5'd11) begin
          if (w != wsd_pkg::TAG_WAVE) begin
            if (err_n == '0) err_n = wsd_pkg::ST_NOT_WAVE;
            phase_n = wsd_pkg::PH_SINK;
          end else begin
            phase_n = wsd_pkg::PH_CHUNK; byte_count_n = '0; tag_n = '0;
          end
        end else byte_count_n = byte_count + 5'd1;
      end
      wsd_pkg::PH_CHUNK: begin
        if (byte_count < 5'd4) tag_n = w;
        else chunk_n = (chunk_left >> 8) | {b, 24'd0};
        byte_count_n = byte_count + 5'd1;
        if (byte_count == 5'd7) begin
          pad_n = chunk_n[0];
          byte_count_n = '0;
          if (tag_shift == wsd_pkg::TAG_FMT && !data_seen) begin
            if (chunk_n < 32'd16) begin
              if (err_n == '0) err_n = wsd_pkg::ST_FMT_INC;
              phase_n = wsd_pkg::PH_SINK;
            end else begin
              fc_n = '0; cc_n = '0; rs_n = '0; sb_n = '0; phase_n = wsd_pkg::PH_FMT;
            end
          end else if (tag_shift == wsd_pkg::TAG_DATA) begin
            if (!fmt_seen) begin
              if (err_n == '0) err_n = wsd_pkg::ST_FMT_INC;
              phase_n = wsd_pkg::PH_SINK;
            end else if (fe != wsd_pkg::ST_OK) begin
              if (err_n == '0) err_n = fe;
              phase_n = wsd_pkg::PH_SINK;
            end else begin
              if (chunk_n != '0) data_n = 1'b1;
              sby_n = sample_bits[5:3]; bis_n = '0; ci_n = '0; ms_n = '0;
              phase_n = wsd_pkg::PH_DATA;
            end
          end else phase_n = wsd_pkg::PH_SKIP;
          if (phase_n != wsd_pkg::PH_SINK) begin
            tag_n = '0;
            if (chunk_n == '0)
              phase_n = pad_n ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHUNK;
          end
        end
      end
      wsd_pkg::PH_FMT: begin
        unique case (byte_count)
          5'd0: fc_n[7:0] = b;
          5'd1: fc_n[15:8] = b;
          5'd2: cc_n[7:0] = b;
          5'd3: cc_n[15:8] = b;
          5'd4: rs_n[7:0] = b;
          5'd5: rs_n[15:8] = b;
          5'd6: rs_n[23:16] = b;
          5'd7: rs_n[31:24] = b;
          5'd14: sb_n[7:0] = b;
          5'd15: sb_n[15:8] = b;
          default: ;
        endcase
        if (byte_count == 5'd15) fmt_n = 1'b1;
        if (byte_count < 5'd16) byte_count_n = byte_count + 5'd1;
        chunk_n = chunk_left - 32'd1;
        if (chunk_n == '0) begin
          phase_n = pad_pending ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHUNK;
          byte_count_n = '0;
        end
      end
      wsd_pkg::PH_DATA: begin
        tag_n = w;
        if ({1'b0, byte_in_sample} + 3'd1 >= sample_bytes) begin
          ms_n = mix_sum + q; tag_n = '0; bis_n = '0;
          ci_n = channel_index + 1'b1;
          if (16'(ci_n) >= channel_count) begin
            frame_n = 1'b1; ci_n = '0;
          end
        end else bis_n = byte_in_sample + 2'd1;
        chunk_n = chunk_left - 32'd1;
        if (chunk_n == '0) begin
          phase_n = pad_pending ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHUNK;
          byte_count_n = '0;
        end
      end
      wsd_pkg::PH_SKIP: begin
        chunk_n = chunk_left - 32'd1;
        if (chunk_n == '0) begin
          phase_n = pad_pending ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHUNK;
          byte_count_n = '0;
        end
      end
      wsd_pkg::PH_PAD: begin
        pad_n = 1'b0; phase_n = wsd_pkg::PH_CHUNK; byte_count_n = '0; tag_n = '0;
      end
      default: ;
    endcase
    // end of file report
    if (eof) begin
      if (phase_n == wsd_pkg::PH_HEADER) begin
        if (err_n == '0) err_n = wsd_pkg::ST_NOT_WAVE;
      end else if (phase_n == wsd_pkg::PH_FMT && byte_count_n < 5'd16) begin
        if (err_n == '0) err_n = wsd_pkg::ST_FMT_INC;
      end else if (phase_n == wsd_pkg::PH_DATA) begin
        if (err_n == '0) err_n = wsd_pkg::ST_TRUNC;
      end
      if (err_n == '0 && !data_n) err_n = wsd_pkg::ST_FMT_INC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase <= wsd_pkg::PH_HEADER; byte_count <= '0; tag_shift <= '0;
      chunk_left <= '0; pad_pending <= 1'b0; format_code <= '0;
      channel_count <= '0; rate_store <= '0; sample_bits <= '0;
      fmt_seen <= 1'b0; data_seen <= 1'b0; sample_bytes <= '0;
      byte_in_sample <= '0; channel_index <= '0; mix_sum <= '0; error_code <= '0;
      frame_done <= 1'b0;
    end else if (cmd.parse) begin
      phase <= phase_n; byte_count <= byte_count_n; tag_shift <= tag_n;
      chunk_left <= chunk_n; pad_pending <= pad_n; format_code <= fc_n;
      channel_count <= cc_n; rate_store <= rs_n; sample_bits <= sb_n;
      fmt_seen <= fmt_n; data_seen <= data_n; sample_bytes <= sby_n;
      byte_in_sample <= bis_n; channel_index <= ci_n;
      mix_sum <= frame_n ? 32'sd0 : ms_n; error_code <= err_n;
      frame_done <= frame_n;
      if (frame_n) div_num <= ms_n;
      fin_kind <= (err_n != '0) ? wsd_pkg::KIND_ERROR : wsd_pkg::KIND_DONE;
      fin_status <= err_n;
      rate_hz <= (err_n != '0) ? 32'd0 : rs_n;
    end
  end

  assign stat = '{frame_done: frame_done, div_busy: div_busy};

  always_comb begin
    if (quo > 32'sd8388607) avg = 24'sh7FFFFF;
    else if (quo < -32'sd8388608) avg = 24'sh800000;
    else avg = quo[23:0];
  end
endmodule

>>> hdl/wsd_ctrl.sv
// ----------------------------------------------------------------------------
// wsd_ctrl
// Sequencer: takes a byte, runs the divide when a frame closes, emits beats.
// ----------------------------------------------------------------------------
module wsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              eof,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_final,
  output logic              out_last,
  output wsd_pkg::dp_cmd_t  cmd,
  input  wsd_pkg::dp_stat_t stat
);
  wsd_pkg::ctrl_state_t state, state_next;
  logic eof_q, started;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsd_pkg::C_IDLE; eof_q <= 1'b0; started <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) eof_q <= eof;
      started <= (state == wsd_pkg::C_IDLE && in_valid) && !started ? 1'b1 : 1'b0;
    end
  end

  // started: the byte was parsed in the previous cycle, its flags are now settled
  always_comb begin
    state_next = state;
    unique case (state)
      wsd_pkg::C_IDLE:
        if (started) begin
          if (stat.frame_done) state_next = wsd_pkg::C_DIV;
          else if (eof_q) state_next = wsd_pkg::C_OUT_FINAL;
        end
      wsd_pkg::C_DIV:
        if (!stat.div_busy && !started) state_next = wsd_pkg::C_OUT_SAMPLE;
      wsd_pkg::C_OUT_SAMPLE:
        if (out_ready) state_next = eof_q ? wsd_pkg::C_OUT_FINAL : wsd_pkg::C_IDLE;
      wsd_pkg::C_OUT_FINAL:
        if (out_ready) state_next = wsd_pkg::C_IDLE;
      default: state_next = wsd_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == wsd_pkg::C_IDLE) && !started;
    cmd.parse = in_valid && in_ready;
    cmd.div_start = (state == wsd_pkg::C_IDLE) && started && stat.frame_done;
    out_valid = (state == wsd_pkg::C_OUT_SAMPLE) || (state == wsd_pkg::C_OUT_FINAL);
    out_final = (state == wsd_pkg::C_OUT_FINAL);
    out_last = out_final || !eof_q;
    cmd.clear = (state == wsd_pkg::C_OUT_FINAL) && out_ready;
  end
endmodule

>>> hdl/wav_stream_decode_downmix_top.sv
// a byte with no result is parsed before the next byte is taken; a byte
// closing a frame gives its sample beat after a bit-serial divide and holds
// the input through the divide and any output stall; the end report follows
// the byte marked eof, after any sample beat that byte gives
// reset: synchronous, active high, clears parser and sequencer; the block
// also returns to its reset state once the end report is taken
// ----------------------------------------------------------------------------
// wav_stream_decode_downmix_top
// RIFF/WAVE byte parser with PCM/float decode and mono downmix.
// ----------------------------------------------------------------------------
module wav_stream_decode_downmix_top (
  input  logic        clk,
  input  logic        rst,
  wsd_stream_if.sink   in_ch,
  wsd_stream_if.source out_ch
);
  wsd_pkg::dp_cmd_t  cmd;
  wsd_pkg::dp_stat_t stat;
  logic out_final, out_last;
  logic signed [23:0] avg;
  logic [1:0]  fin_kind;
  logic [2:0]  fin_status;
  logic [31:0] rate_hz;

  wsd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .eof(in_ch.data[8]), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_final(out_final), .out_last(out_last), .cmd(cmd), .stat(stat)
  );

  wsd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .b(in_ch.data[7:0]), .eof(in_ch.data[8]),
    .stat(stat), .avg(avg), .fin_kind(fin_kind), .fin_status(fin_status),
    .rate_hz(rate_hz)
  );

  // payload: run_end, status, rate_hz, sample, kind
  assign out_ch.data = out_final
    ? {1'b1, fin_status, rate_hz, 24'd0, fin_kind}
    : {out_last, wsd_pkg::ST_OK, 32'd0, avg, wsd_pkg::KIND_SAMPLE};
endmodule

>>> hdl/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the decoder's input and output channels.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [61:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[1:0] != 2'd3)
    else $error("bad result kind");
  a_final_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[1:0] != 2'd0 |-> out_data[61])
    else $error("final report not marked run end");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  // a taken byte is parsed before the next one is allowed in
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input beats taken back to back");
endmodule

bind wav_stream_decode_downmix_top wsd_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

>>> dv/wav_stream_decode_downmix_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_decode_downmix_top_test
// Feeds whole WAV files byte by byte: a short table of header faults with the
// reports written out, then random files (PCM 16/24/32, float32, junk chunks,
// pads, bad formats, cut files, noise). Results of the random files are checked
// against a cycle-free model of the parser and downmixer kept in this testbench.
// ----------------------------------------------------------------------------
module wav_stream_decode_downmix_top_test;

  localparam int IdleLimit = 4000;
  localparam int Settle = 60;

  typedef struct {
    logic [7:0] b;
    logic       eof;
    bit         typed;
    logic [1:0] tkind;
    logic [2:0] tstatus;
    bit         drain;
    bit         hold;
  } byte_item_t;

  // same bit order as the output payload, run_end on top
  typedef struct packed {
    logic        run_end;
    logic [2:0]  status;
    logic [31:0] rate;
    logic [23:0] sample;
    logic [1:0]  kind;
  } report_t;

  logic clk = 0;
  logic rst = 1;

  wsd_stream_if #(.W(9))  in_ch (clk);
  wsd_stream_if #(.W(62)) out_ch (clk);

  wav_stream_decode_downmix_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  byte_item_t file_q[$];
  logic [7:0] fb[$];
  report_t    pending_reports[$];
  int n_acc = 0, n_err = 0, n_samples = 0, n_done = 0, n_fail = 0, n_files = 0;
  int hold_reqs = 0, hold_done = 0;

  // ---------------- decoder model ----------------
  wsd_pkg::phase_t m_ph;
  logic [31:0] m_cnt, m_shift, m_left, m_rate, m_sbytes;
  logic        m_pad, m_fseen, m_dseen;
  logic [15:0] m_fmt, m_chans, m_bits;
  logic [31:0] m_bis, m_cidx;
  int          m_sum;
  logic [2:0]  m_err;

  function automatic void model_clear();
    m_ph = wsd_pkg::PH_HEADER;
    m_cnt = 0; m_shift = 0; m_left = 0; m_pad = 0;
    m_fmt = 0; m_chans = 0; m_rate = 0; m_bits = 0;
    m_fseen = 0; m_dseen = 0; m_sbytes = 0; m_bis = 0; m_cidx = 0;
    m_sum = 0; m_err = wsd_pkg::ST_OK;
  endfunction

  function automatic void latch_fault(logic [2:0] c);
    if (m_err == wsd_pkg::ST_OK) m_err = c;
    m_ph = wsd_pkg::PH_SINK;
  endfunction

  function automatic int to_q23_float(logic [31:0] w);
    int e;
    logic [31:0] man, mag;
    e = w[30:23];
    man = {8'd0, 1'b1, w[22:0]};
    if (e == 255 || e == 0) mag = 0;
    else if (e >= 130) mag = 32'd1 << 26;
    else if (e >= 127) mag = man << (e - 127);
    else if (127 - e >= 24) mag = 0;
    else mag = man >> (127 - e);
    return w[31] ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [2:0] format_fault();
    if (m_chans == 0 || m_rate == 0) return wsd_pkg::ST_FMT_INC;
    if (m_bits / 8 == 0) return wsd_pkg::ST_DEPTH;
    if (m_chans > wsd_pkg::MaxChannels) return wsd_pkg::ST_UNSUPP;
    if (m_fmt == 1 && (m_bits == 16 || m_bits == 24 || m_bits == 32)) return wsd_pkg::ST_OK;
    if (m_fmt == 3 && m_bits == 32) return wsd_pkg::ST_OK;
    return wsd_pkg::ST_UNSUPP;
  endfunction

  function automatic void close_body();
    m_ph = m_pad ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHUNK;
    m_cnt = 0;
  endfunction

  function automatic void start_chunk();
    logic [2:0] e;
    m_pad = m_left[0];
    m_cnt = 0;
    if (m_shift == wsd_pkg::TAG_FMT && !m_dseen) begin
      if (m_left < 16) begin
        latch_fault(wsd_pkg::ST_FMT_INC);
        return;
      end
      m_fmt = 0; m_chans = 0; m_rate = 0; m_bits = 0;
      m_ph = wsd_pkg::PH_FMT;
    end else if (m_shift == wsd_pkg::TAG_DATA) begin
      if (!m_fseen) begin
        latch_fault(wsd_pkg::ST_FMT_INC);
        return;
      end
      e = format_fault();
      if (e != wsd_pkg::ST_OK) begin
        latch_fault(e);
        return;
      end
      if (m_left != 0) m_dseen = 1;
      m_sbytes = m_bits / 8;
      m_bis = 0; m_cidx = 0; m_sum = 0;
      m_ph = wsd_pkg::PH_DATA;
    end else begin
      m_ph = wsd_pkg::PH_SKIP;
    end
    m_shift = 0;
    if (m_left == 0) close_body();
  endfunction

  function automatic report_t mk_report(logic [1:0] k, logic [23:0] s, logic [31:0] r,
                                        logic [2:0] st);
    report_t x;
    x.kind = k; x.sample = s; x.rate = r; x.status = st; x.run_end = 0;
    return x;
  endfunction

  // returns the reports caused by one byte
  function automatic void decode_byte(logic [7:0] b, logic eof, ref report_t res[$]);
    int q, avg;
    logic [31:0] o;
    res.delete();
    case (m_ph)
      wsd_pkg::PH_HEADER: begin
        m_shift = {b, m_shift[31:8]};
        if (m_cnt == 3 && m_shift != wsd_pkg::TAG_RIFF) latch_fault(wsd_pkg::ST_NOT_WAVE);
        else if (m_cnt == 11) begin
          if (m_shift != wsd_pkg::TAG_WAVE) latch_fault(wsd_pkg::ST_NOT_WAVE);
          else begin
            m_ph = wsd_pkg::PH_CHUNK; m_cnt = 0; m_shift = 0;
          end
        end else m_cnt++;
      end
      wsd_pkg::PH_CHUNK: begin
        if (m_cnt < 4) m_shift = {b, m_shift[31:8]};
        else m_left = {b, m_left[31:8]};
        m_cnt++;
        if (m_cnt == 8) start_chunk();
      end
      wsd_pkg::PH_FMT: begin
        o = m_cnt;
        if (o <= 1) m_fmt[8*o +: 8] = b;
        else if (o <= 3) m_chans[8*(o-2) +: 8] = b;
        else if (o <= 7) m_rate[8*(o-4) +: 8] = b;
        else if (o == 14 || o == 15) m_bits[8*(o-14) +: 8] = b;
        if (o == 15) m_fseen = 1;
        if (o < 16) m_cnt++;
        m_left--;
        if (m_left == 0) close_body();
      end
      wsd_pkg::PH_DATA: begin
        m_shift = {b, m_shift[31:8]};
        if (m_bis + 1 >= m_sbytes) begin
          q = (m_fmt == 3) ? to_q23_float(m_shift) : ($signed(m_shift) >>> 8);
          m_sum += q;
          m_shift = 0; m_bis = 0;
          m_cidx++;
          if (m_cidx >= m_chans) begin
            avg = m_sum / int'(m_chans);
            if (avg > 8388607) avg = 8388607;
            if (avg < -8388608) avg = -8388608;
            res.push_back(mk_report(wsd_pkg::KIND_SAMPLE, avg[23:0], 0, wsd_pkg::ST_OK));
            m_sum = 0; m_cidx = 0;
          end
        end else m_bis++;
        m_left--;
        if (m_left == 0) close_body();
      end
      wsd_pkg::PH_SKIP: begin
        m_left--;
        if (m_left == 0) close_body();
      end
      wsd_pkg::PH_PAD: begin
        m_pad = 0; m_ph = wsd_pkg::PH_CHUNK; m_cnt = 0; m_shift = 0;
      end
      default: ;
    endcase
    if (eof) begin
      if (m_ph == wsd_pkg::PH_HEADER) latch_fault(wsd_pkg::ST_NOT_WAVE);
      else if (m_ph == wsd_pkg::PH_FMT && m_cnt < 16) latch_fault(wsd_pkg::ST_FMT_INC);
      else if (m_ph == wsd_pkg::PH_DATA) latch_fault(wsd_pkg::ST_TRUNC);
      if (m_err == wsd_pkg::ST_OK && !m_dseen) latch_fault(wsd_pkg::ST_FMT_INC);
      if (m_err != wsd_pkg::ST_OK)
        res.push_back(mk_report(wsd_pkg::KIND_ERROR, 0, 0, m_err));
      else res.push_back(mk_report(wsd_pkg::KIND_DONE, 0, m_rate, wsd_pkg::ST_OK));
      model_clear();
    end
    if (res.size() > 0) res[res.size()-1].run_end = 1;
  endfunction

  // ---------------- stimulus building ----------------
  function automatic void add_row(logic [7:0] b, logic eof, bit typed = 0,
                                  logic [1:0] k = wsd_pkg::KIND_ERROR,
                                  logic [2:0] st = wsd_pkg::ST_OK);
    byte_item_t it;
    it = '{b: b, eof: eof, typed: typed, tkind: k, tstatus: st, drain: 0, hold: 0};
    file_q.push_back(it);
  endfunction

  function automatic void put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) fb.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_tag(logic [31:0] tag);
    put32(tag);
  endfunction

  function automatic void put_fmt(logic [31:0] size, logic [15:0] fc, logic [15:0] ch,
                                  logic [31:0] rate, logic [15:0] bits);
    put_tag(wsd_pkg::TAG_FMT);
    put32(size);
    for (int i = 0; i < size; i++) begin
      case (i)
        0: fb.push_back(fc[7:0]);
        1: fb.push_back(fc[15:8]);
        2: fb.push_back(ch[7:0]);
        3: fb.push_back(ch[15:8]);
        4, 5, 6, 7: fb.push_back(rate[8*(i-4) +: 8]);
        14: fb.push_back(bits[7:0]);
        15: fb.push_back(bits[15:8]);
        default: fb.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (size[0]) fb.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_junk();
    int n;
    n = $urandom_range(0, 5);
    put32($urandom());
    put32(32'(n));
    repeat (n + (n % 2)) fb.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_sample(int nbytes, bit is_float);
    logic [31:0] w;
    int pick;
    w = $urandom();
    pick = $urandom_range(0, 9);
    if (is_float) begin
      case ($urandom_range(0, 11))
        0: w[30:23] = 8'd0;
        1: w[30:23] = 8'hFF;
        2: w[30:23] = 8'(130 + $urandom_range(0, 100));
        3: w[30:23] = 8'd103;
        4: w[30:23] = 8'd104;
        5: w[30:23] = 8'd127;
        6: w[30:23] = 8'd129;
        7: w[30:23] = 8'($urandom_range(1, 102));
        default: w[30:23] = 8'($urandom_range(118, 128));
      endcase
    end else if (pick == 0) begin
      w = 32'h7FFFFFFF;
    end else if (pick == 1) begin
      w = 32'h80000000;
    end
    for (int i = 4 - nbytes; i < 4; i++) fb.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_data(int ch, int bits, bit is_float, int frames, int partial);
    int size;
    size = frames * ch * (bits / 8) + partial;
    put_tag(wsd_pkg::TAG_DATA);
    put32(32'(size));
    repeat (frames * ch) put_sample(bits / 8, is_float);
    repeat (partial) fb.push_back(8'($urandom_range(0, 255)));
    if (size % 2) fb.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_file(bit drain, bit hold);
    int fc, ch, bits, frames, partial, mode, cut;
    logic [31:0] rate;
    bit is_float;
    fb.delete();
    mode = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: begin fc = 1; bits = 16; end
      1: begin fc = 1; bits = 24; end
      2: begin fc = 1; bits = 32; end
      default: begin fc = 3; bits = 32; end
    endcase
    is_float = (fc == 3);
    ch = ($urandom_range(0, 4) == 0) ? $urandom_range(1, wsd_pkg::MaxChannels)
                                     : $urandom_range(1, 2);
    rate = ($urandom_range(0, 3) == 0) ? $urandom() : 48000;
    if (mode < 3) begin
      // plain noise
      repeat ($urandom_range(1, 20)) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_tag((mode < 6) ? $urandom() : wsd_pkg::TAG_RIFF);
      put32($urandom());
      put_tag((mode >= 6 && mode < 8) ? wsd_pkg::TAG_RIFF : wsd_pkg::TAG_WAVE);
      if ($urandom_range(0, 3) == 0) put_junk();
      if (mode >= 8 && mode < 12) begin
        put_data(ch, bits, is_float, 1, 0);
      end
      if (mode >= 12 && mode < 20) begin
        // broken format fields
        case ($urandom_range(0, 6))
          0: put_fmt(16, 16'(fc), 0, rate, 16'(bits));
          1: put_fmt(16, 16'(fc), 16'(ch), 0, 16'(bits));
          2: put_fmt(16, 16'(fc), 16'(ch), rate, 16'($urandom_range(0, 7)));
          3: put_fmt(16, 16'(fc), 16'($urandom_range(wsd_pkg::MaxChannels + 1, 65535)),
                     rate, 16'(bits));
          4: put_fmt(16, 2, 16'(ch), rate, 16'(bits));
          5: put_fmt(16, 3, 16'(ch), rate, 16);
          default: put_fmt(16, 1, 16'(ch), rate, 8);
        endcase
      end else if (mode >= 20 && mode < 24) begin
        put_tag(wsd_pkg::TAG_FMT);
        put32($urandom_range(0, 15));
        repeat (8) fb.push_back(8'($urandom_range(0, 255)));
      end else begin
        put_fmt(($urandom_range(0, 3) == 0) ? $urandom_range(17, 19) : 16, 16'(fc),
                16'(ch), rate, 16'(bits));
      end
      if ($urandom_range(0, 4) == 0) put_junk();
      frames = (mode < 27) ? 0 : $urandom_range(1, 6);
      partial = ($urandom_range(0, 6) == 0) ? $urandom_range(1, ch * (bits / 8)) : 0;
      put_data(ch, bits, is_float, frames, (frames == 0) ? 0 : partial);
      if ($urandom_range(0, 5) == 0) put_fmt(16, 16'(fc), 16'(ch), rate, 16'(bits));
      if ($urandom_range(0, 5) == 0) put_data(ch, bits, is_float, $urandom_range(1, 3), 0);
      if ($urandom_range(0, 5) == 0) put_junk();
      if (mode >= 90) begin
        cut = $urandom_range(1, fb.size());
        while (fb.size() > cut) void'(fb.pop_back());
      end
    end
    foreach (fb[i]) add_row(fb[i], i == fb.size() - 1);
    file_q[file_q.size() - fb.size()].drain = drain;
    file_q[file_q.size() - fb.size()].hold = hold;
    n_files++;
  endfunction

  // ---------------- acceptance and prediction ----------------
  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;

  always @(posedge clk) begin
    report_t fresh[$];
    report_t r;
    if (!rst && in_fire) begin
      decode_byte(in_ch.data[7:0], in_ch.data[8], fresh);
      if (file_q[n_acc].typed) begin
        r = mk_report(file_q[n_acc].tkind, 0, 0, file_q[n_acc].tstatus);
        r.run_end = 1;
        pending_reports.push_back(r);
      end else begin
        foreach (fresh[i]) pending_reports.push_back(fresh[i]);
      end
      n_acc++;
    end
  end

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    report_t got, want;
    if (!rst && out_fire) begin
      got = out_ch.data;
      if (pending_reports.size() == 0) begin
        $error("unexpected beat: kind %0d sample %0h status %0d", got.kind, got.sample,
               got.status);
        n_err++;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("sample", want.sample, got.sample);
        check_field("rate_hz", want.rate, got.rate);
        check_field("status", want.status, got.status);
        check_field("run_end", want.run_end, got.run_end);
        if (want.kind == wsd_pkg::KIND_SAMPLE) n_samples++;
        else if (want.kind == wsd_pkg::KIND_DONE) n_done++;
        else n_fail++;
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int run_left, stall_left;
    run_left = 0;
    stall_left = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ch.ready <= 1;
        run_left--;
      end else begin
        run_left = $urandom_range(1, 30);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // ---------------- sender and run control ----------------
  initial begin
    int burst_left, gap;
    in_ch.valid = 0;
    in_ch.data = '0;
    model_clear();

    // end inside header
    add_row(8'h52, 1, 1, wsd_pkg::KIND_ERROR, wsd_pkg::ST_NOT_WAVE);
    // bad riff tag, reported at end of file
    add_row("R", 0); add_row("I", 0); add_row("F", 0); add_row("X", 0);
    add_row(8'h00, 1, 1, wsd_pkg::KIND_ERROR, wsd_pkg::ST_NOT_WAVE);
    // good header, max size, end inside chunk header with no data
    add_row("R", 0); add_row("I", 0); add_row("F", 0); add_row("F", 0);
    repeat (4) add_row(8'hFF, 0);
    add_row("W", 0); add_row("A", 0); add_row("V", 0); add_row("E", 0);
    add_row("f", 1, 1, wsd_pkg::KIND_ERROR, wsd_pkg::ST_FMT_INC);
    while (file_q.size() < 1850) begin
      build_file(n_files % 60 == 30, n_files == 12);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    burst_left = 0;
    for (int i = 0; i < file_q.size(); i++) begin
      @(negedge clk);
      if (file_q[i].drain) begin
        in_ch.valid <= 0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (Settle) @(negedge clk);
        burst_left = 0;
      end
      if (file_q[i].hold) hold_reqs++;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_ch.valid <= 0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      in_ch.valid <= 1;
      in_ch.data <= {file_q[i].eof, file_q[i].b};
      while (n_acc <= i) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      n_err++;
    end
    $display("run: %0d files, %0d bytes in", n_files, n_acc);
    $display("seen: %0d samples, %0d clean ends, %0d error reports", n_samples, n_done,
             n_fail);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
